/* sv/vic_pkg.sv */
package vic_pkg;

  localparam int unsigned LineCountDefault = 7;
  localparam int unsigned MaskW            = 8;
  localparam int unsigned DataW            = 64;
  localparam int unsigned VecW             = 8;
  localparam int unsigned LineW            = 8;
  localparam int unsigned CfgIdxW          = 8;
  localparam int unsigned CfgDataW         = 8;
  localparam int unsigned InTdataW         = 80;
  localparam int unsigned OutTdataW        = 72;

  localparam logic [VecW-1:0]     VectorBaseReset = 8'd32;
  localparam logic [MaskW-1:0]    ControlReset    = 8'h01;
  localparam logic [CfgIdxW-1:0]  CfgDeviceEnabled = 8'd0;
  localparam logic [CfgIdxW-1:0]  CfgVectorBase    = 8'd1;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_SIGNAL  = 2'd2,
    OP_DELIVER = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_PENDING = 3'd0,
    REG_ENABLE  = 3'd1,
    REG_VECTORS = 3'd2,
    REG_CONTROL = 3'd3
  } reg_e;

  typedef enum logic [0:0] {
    KIND_READ   = 1'b0,
    KIND_VECTOR = 1'b1
  } kind_e;

  typedef enum logic [0:0] {
    ST_IDLE    = 1'b0,
    ST_DELIVER = 1'b1
  } state_e;

  typedef struct packed {
    logic do_read;
    logic do_write;
    logic do_signal;
    logic do_emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic dev_en;
    logic ctl_go;
    logic cand_any;
    logic last_one;
  } sts_t;

endpackage

/* sv/vectored_interrupt_controller.sv */
// A read result is registered and appears in the cycle after the item is accepted.
// Reads, writes and signals are accepted one per cycle while the output register
// is free; a deliver blocks new items while it emits one pending and enabled line
// per cycle, lowest first, through the single output register, stalling while it holds an untaken result.
// Reset (rst_ni low, asynchronous) clears pending, enables all lines, loads
// the default vector table and control word, and empties the output register.
module vectored_interrupt_controller #(
  parameter int unsigned LINE_COUNT = vic_pkg::LineCountDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // reg_select[2:0], write_data[66:3], line[74:67], zero[79:75]
  input  logic [vic_pkg::InTdataW-1:0]    s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // read_data[63:0], vector[71:64]
  output logic [vic_pkg::OutTdataW-1:0]   m_axis_tdata,
  // kind[0]
  output logic [0:0]                      m_axis_tuser,
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vic_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [vic_pkg::CfgDataW-1:0]    cfg_data_i
);
  import vic_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  kind_e            out_kind;
  logic [DataW-1:0] out_data;
  logic [VecW-1:0]  out_vec;

  assign cfg_ready_o = 1'b1;

  vic_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .op_i      (op_e'(s_axis_tuser)),
    .sts_i     (sts),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  vic_dp #(
    .LINE_COUNT (LINE_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sel_i       (s_axis_tdata[2:0]),
    .wdata_i     (s_axis_tdata[66:3]),
    .line_i      (s_axis_tdata[74:67]),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_data_o  (out_data),
    .out_vec_o   (out_vec),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_vec, out_data};
  assign m_axis_tuser = out_kind;

  a_read_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_READ |-> m_axis_tlast)
    else $error("read result without last");

  a_vector_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_VECTOR |-> m_axis_tdata[63:0] == '0)
    else $error("vector result carries read data");

  a_read_no_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_READ |-> m_axis_tdata[71:64] == '0)
    else $error("read result carries a vector");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.do_read, cmd.do_write, cmd.do_signal, cmd.do_emit}))
    else $error("conflicting datapath commands");

endmodule

/* sv/vic_ctrl.sv */
module vic_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  vic_pkg::op_e  op_i,
  input  vic_pkg::sts_t sts_i,
  output logic          s_ready_o,
  output vic_pkg::cmd_t cmd_o
);
  import vic_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    s_ready_o = 1'b0;
    cmd_o     = '0;
    accept    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = sts_i.out_free;
        accept    = s_valid_i && sts_i.out_free;
        if (accept) begin
          case (op_i)
            OP_READ:    cmd_o.do_read   = 1'b1;
            OP_WRITE:   cmd_o.do_write  = sts_i.dev_en;
            OP_SIGNAL:  cmd_o.do_signal = sts_i.dev_en;
            OP_DELIVER: begin
              if (sts_i.dev_en && sts_i.ctl_go && sts_i.cand_any) begin
                state_d = ST_DELIVER;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DELIVER: begin
        if (sts_i.out_free) begin
          cmd_o.do_emit = 1'b1;
          if (sts_i.last_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* sv/vic_dp.sv */
module vic_dp #(
  parameter int unsigned LINE_COUNT = vic_pkg::LineCountDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vic_pkg::cmd_t                 cmd_i,
  output vic_pkg::sts_t                 sts_o,
  input  logic [2:0]                    sel_i,
  input  logic [vic_pkg::DataW-1:0]     wdata_i,
  input  logic [vic_pkg::LineW-1:0]     line_i,
  input  logic                          cfg_we_i,
  input  logic [vic_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [vic_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output vic_pkg::kind_e                out_kind_o,
  output logic [vic_pkg::DataW-1:0]     out_data_o,
  output logic [vic_pkg::VecW-1:0]      out_vec_o,
  output logic                          out_last_o
);
  import vic_pkg::*;

  function automatic logic [DataW-1:0] vtab_reset();
    logic [DataW-1:0] v;
    v = '0;
    for (int n = 0; n < LINE_COUNT; n++) begin
      v[VecW*n +: VecW] = VectorBaseReset + VecW'(n);
    end
    return v;
  endfunction

  localparam logic [MaskW-1:0] LineMask  = MaskW'((9'd1 << LINE_COUNT) - 9'd1);
  localparam logic [DataW-1:0] VtabReset = vtab_reset();

  logic             dev_en_q;
  logic [VecW-1:0]  base_q;
  logic [MaskW-1:0] pend_q, pend_d;
  logic [MaskW-1:0] enab_q, enab_d;
  logic [DataW-1:0] vtab_q, vtab_d;
  logic [MaskW-1:0] ctl_q, ctl_d;

  logic             out_valid_q;
  kind_e            out_kind_q;
  logic [DataW-1:0] out_data_q;
  logic [VecW-1:0]  out_vec_q;
  logic             out_last_q;

  logic [MaskW-1:0] cand;
  logic [2:0]       idx;
  logic [MaskW-1:0] pick;
  logic [VecW-1:0]  vbyte;
  logic [VecW-1:0]  vec;
  logic [DataW-1:0] rdata;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;
  assign cand     = pend_q & enab_q;

  always_comb begin
    idx = '0;
    for (int n = MaskW - 1; n >= 0; n--) begin
      if (cand[n]) begin
        idx = 3'(n);
      end
    end
  end

  assign pick  = MaskW'(1) << idx;
  assign vbyte = vtab_q[{idx, 3'b000} +: VecW];
  assign vec   = (vbyte == '0) ? base_q + VecW'(idx) : vbyte;

  assign sts_o.out_free = out_free;
  assign sts_o.dev_en   = dev_en_q;
  assign sts_o.ctl_go   = ctl_q[0];
  assign sts_o.cand_any = cand != '0;
  assign sts_o.last_one = (cand & ~pick) == '0;

  always_comb begin
    rdata = '0;
    if (dev_en_q) begin
      case (sel_i)
        REG_PENDING: rdata = DataW'(pend_q);
        REG_ENABLE:  rdata = DataW'(enab_q);
        REG_VECTORS: rdata = vtab_q;
        REG_CONTROL: rdata = DataW'(ctl_q);
        default:     rdata = '0;
      endcase
    end
  end

  always_comb begin
    pend_d = pend_q;
    enab_d = enab_q;
    vtab_d = vtab_q;
    ctl_d  = ctl_q;
    if (cmd_i.do_write) begin
      case (sel_i)
        REG_PENDING: pend_d = pend_q & ~wdata_i[MaskW-1:0];
        REG_ENABLE:  enab_d = wdata_i[MaskW-1:0] & LineMask;
        REG_VECTORS: vtab_d = wdata_i;
        REG_CONTROL: ctl_d  = wdata_i[MaskW-1:0];
        default: ;
      endcase
    end
    if (cmd_i.do_signal && (line_i < LineW'(LINE_COUNT))) begin
      pend_d = pend_q | (MaskW'(1) << line_i[2:0]);
    end
    if (cmd_i.do_emit) begin
      pend_d = pend_q & ~pick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_en_q    <= 1'b1;
      base_q      <= VectorBaseReset;
      pend_q      <= '0;
      enab_q      <= LineMask;
      ctl_q       <= ControlReset;
      vtab_q      <= VtabReset;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      enab_q <= enab_d;
      vtab_q <= vtab_d;
      ctl_q  <= ctl_d;
      if (cfg_we_i && cfg_index_i == CfgDeviceEnabled) begin
        dev_en_q <= cfg_data_i[0];
      end
      if (cfg_we_i && cfg_index_i == CfgVectorBase) begin
        base_q <= cfg_data_i;
      end
      if (cmd_i.do_read || cmd_i.do_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_read) begin
      out_kind_q <= KIND_READ;
      out_data_q <= rdata;
      out_vec_q  <= '0;
      out_last_q <= 1'b1;
    end else if (cmd_i.do_emit) begin
      out_kind_q <= KIND_VECTOR;
      out_data_q <= '0;
      out_vec_q  <= vec;
      out_last_q <= (cand & ~pick) == '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_data_o  = out_data_q;
  assign out_vec_o   = out_vec_q;
  assign out_last_o  = out_last_q;

endmodule

/* dv/vectored_interrupt_controller_test.sv */
`timescale 1ns / 100ps

module vectored_interrupt_controller_test;
  import vic_pkg::*;

  localparam int unsigned Lines = LineCountDefault;
  localparam logic [7:0] LineMask = 8'hFF >> (8 - Lines);
  localparam logic [2:0] RegSpareLo = 3'd4;
  localparam logic [2:0] RegSpareHi = 3'd7;
  localparam logic [CfgIdxW-1:0] CfgSpare = 8'hF2;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned SettleCycles = 12;

  typedef struct packed {
    logic        kind;
    logic [63:0] rdata;
    logic [7:0]  vec;
    logic        last;
  } irq_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic [1:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  // Predicted controller state
  logic        dev_en;
  logic [7:0]  vbase;
  logic [7:0]  pend;
  logic [7:0]  enab;
  logic [63:0] vtab;
  logic [7:0]  ctrl;

  irq_result_t vector_read_q[$];

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_reqs = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  bit          no_gaps = 1'b0;

  vectored_interrupt_controller #(.LINE_COUNT(Lines)) dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void reset_model();
    int n;
    dev_en = 1'b1;
    vbase  = VectorBaseReset;
    pend   = '0;
    enab   = LineMask;
    ctrl   = ControlReset;
    vtab   = '0;
    for (n = 0; n < Lines; n++) vtab[8*n +: 8] = VectorBaseReset + 8'(n);
  endfunction

  task automatic apply_operation(op_e op, logic [2:0] sel, logic [63:0] wdata,
                                 logic [7:0] ln);
    irq_result_t r;
    logic [7:0]  ready_lines;
    logic [7:0]  b;
    int          n;
    r = '0;
    if (op == OP_READ) begin
      r.kind = KIND_READ;
      r.last = 1'b1;
      if (dev_en) begin
        case (sel)
          REG_PENDING: r.rdata = {56'd0, pend};
          REG_ENABLE:  r.rdata = {56'd0, enab};
          REG_VECTORS: r.rdata = vtab;
          REG_CONTROL: r.rdata = {56'd0, ctrl};
          default:     r.rdata = '0;
        endcase
      end
      vector_read_q.push_back(r);
    end else if (dev_en) begin
      case (op)
        OP_WRITE: begin
          case (sel)
            REG_PENDING: pend = pend & ~wdata[7:0];
            REG_ENABLE:  enab = wdata[7:0] & LineMask;
            REG_VECTORS: vtab = wdata;
            REG_CONTROL: ctrl = wdata[7:0];
            default: ;
          endcase
        end
        OP_SIGNAL: begin
          if (ln < Lines) pend[ln[2:0]] = 1'b1;
        end
        default: begin
          if (ctrl[0]) begin
            ready_lines = pend & enab;
            for (n = 0; n < Lines; n++) begin
              if (ready_lines[n]) begin
                pend[n] = 1'b0;
                b = vtab[8*n +: 8];
                r.kind = KIND_VECTOR;
                r.vec  = (b != 8'd0) ? b : vbase + 8'(n);
                r.last = (ready_lines >> (n + 1)) == 8'd0;
                vector_read_q.push_back(r);
              end
            end
          end
        end
      endcase
    end
  endtask

  task automatic send_item(op_e op, logic [2:0] sel, logic [63:0] wdata, logic [7:0] ln);
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'd0, ln, wdata, sel};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    apply_operation(op, sel, wdata, ln);
    items_sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (vector_read_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    settle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    if (idx == CfgDeviceEnabled) dev_en = val[0];
    else if (idx == CfgVectorBase) vbase = val;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_item();
    op_e         op;
    logic [2:0]  sel;
    logic [63:0] wdata;
    logic [7:0]  ln;
    int unsigned pick;
    int          k;
    pick  = $urandom_range(99);
    sel   = 3'($urandom_range(7));
    wdata = {$urandom, $urandom};
    ln    = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(Lines));
    if (pick < 40) op = OP_SIGNAL;
    else if (pick < 62) op = OP_DELIVER;
    else if (pick < 80) op = OP_READ;
    else begin
      op  = OP_WRITE;
      sel = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
      if (sel == REG_CONTROL && $urandom_range(3) != 0) wdata[0] = 1'b1;
      if (sel == REG_VECTORS)
        for (k = 0; k < 8; k++) if ($urandom_range(2) == 0) wdata[8*k +: 8] = 8'd0;
    end
    send_item(op, sel, wdata, ln);
  endtask

  task automatic test_register_map();
    send_item(OP_READ, REG_PENDING, '0, '0);
    send_item(OP_READ, REG_ENABLE, '0, '0);
    send_item(OP_READ, REG_VECTORS, '0, '0);
    send_item(OP_READ, REG_CONTROL, '0, '0);
    send_item(OP_READ, RegSpareHi, '0, '0);
    send_item(OP_WRITE, REG_ENABLE, '1, '0);
    send_item(OP_WRITE, REG_CONTROL, 64'hFFFF_FFFF_FFFF_FF00, '0);
    send_item(OP_WRITE, REG_VECTORS, 64'h00FF_0000_0000_0100, '0);
    send_item(OP_WRITE, RegSpareLo, '1, '0);
    send_item(OP_READ, REG_ENABLE, '0, '0);
    send_item(OP_READ, REG_CONTROL, '0, '0);
    send_item(OP_READ, REG_VECTORS, '0, '0);
  endtask

  task automatic test_signal_deliver();
    send_item(OP_SIGNAL, '0, '0, 8'd0);
    send_item(OP_SIGNAL, '0, '0, 8'd6);
    send_item(OP_SIGNAL, '0, '0, 8'd7);
    send_item(OP_SIGNAL, '0, '0, 8'd255);
    send_item(OP_DELIVER, '0, '0, '0);
    send_item(OP_WRITE, REG_CONTROL, 64'h1, '0);
    send_item(OP_DELIVER, '0, '0, '0);
    send_item(OP_DELIVER, '0, '0, '0);
    send_item(OP_SIGNAL, '0, '0, 8'd1);
    send_item(OP_SIGNAL, '0, '0, 8'd3);
    send_item(OP_WRITE, REG_PENDING, 64'hFFFF_FFFF_FFFF_FF02, '0);
    send_item(OP_READ, REG_PENDING, '0, '0);
    send_item(OP_DELIVER, '0, '0, '0);
  endtask

  task automatic test_config();
    write_cfg(CfgVectorBase, 8'hFF);
    send_item(OP_WRITE, REG_VECTORS, '0, '0);
    send_item(OP_SIGNAL, '0, '0, 8'd0);
    send_item(OP_SIGNAL, '0, '0, 8'd1);
    send_item(OP_SIGNAL, '0, '0, 8'd6);
    send_item(OP_DELIVER, '0, '0, '0);
    write_cfg(CfgVectorBase, 8'h00);
    send_item(OP_SIGNAL, '0, '0, 8'd3);
    send_item(OP_DELIVER, '0, '0, '0);
    write_cfg(CfgSpare, 8'hA5);
    write_cfg(CfgDeviceEnabled, 8'hFE);
    send_item(OP_READ, REG_ENABLE, '0, '0);
    send_item(OP_WRITE, REG_CONTROL, '0, '0);
    send_item(OP_SIGNAL, '0, '0, 8'd2);
    send_item(OP_DELIVER, '0, '0, '0);
    write_cfg(CfgDeviceEnabled, 8'h01);
    send_item(OP_READ, REG_CONTROL, '0, '0);
    send_item(OP_READ, REG_PENDING, '0, '0);
  endtask

  task automatic test_backpressure();
    int n;
    write_cfg(CfgVectorBase, 8'h40);
    send_item(OP_WRITE, REG_ENABLE, '1, '0);
    send_item(OP_WRITE, REG_CONTROL, 64'h1, '0);
    hold_reqs++;
    repeat (2) begin
      for (n = 0; n < Lines; n++) send_item(OP_SIGNAL, '0, '0, 8'(n));
      send_item(OP_DELIVER, '0, '0, '0);
    end
    send_item(OP_READ, REG_PENDING, '0, '0);
  endtask

  task automatic test_random();
    int          ph;
    logic [7:0]  base;
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       base = 8'hFF;
        1:       base = 8'h00;
        default: base = 8'($urandom);
      endcase
      write_cfg(CfgVectorBase, base);
      no_gaps = (ph == 2);
      repeat ((ph == 2) ? 20 : 10) send_random_item();
    end
    no_gaps = 1'b0;
    write_cfg(CfgDeviceEnabled, 8'($urandom) & 8'hFE);
    repeat (6) send_random_item();
    write_cfg(CfgDeviceEnabled, 8'($urandom) | 8'h01);
    repeat (7) send_random_item();
  endtask

  always @(negedge clk_i) begin
    if (holds_served != hold_reqs) begin
      holds_served = hold_reqs;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_gaps || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk_i) begin
    irq_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (vector_read_q.size() == 0) begin
        if (errors < 10)
          $display("ERROR: unexpected result kind %0d data %h vector %h last %b",
                   m_axis_tuser[0], m_axis_tdata[63:0], m_axis_tdata[71:64], m_axis_tlast);
        errors++;
      end else begin
        want = vector_read_q.pop_front();
        if (m_axis_tuser[0] !== want.kind || m_axis_tdata[63:0] !== want.rdata ||
            m_axis_tdata[71:64] !== want.vec || m_axis_tlast !== want.last) begin
          if (errors < 10)
            $display({"ERROR result %0d: exp kind %0d data %h vector %h last %b, ",
                      "got kind %0d data %h vector %h last %b"},
                     results_checked, want.kind, want.rdata, want.vec, want.last,
                     m_axis_tuser[0], m_axis_tdata[63:0], m_axis_tdata[71:64],
                     m_axis_tlast);
          errors++;
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else if (rst_ni) begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, vector_read_q.size());
        $display("vectored_interrupt_controller: mismatch");
        $finish;
      end
    end
  end

  initial begin
    reset_model();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_register_map();
    test_signal_deliver();
    test_config();
    test_backpressure();
    test_random();
    settle();
    $display("Run covered %0d items, %0d results and %0d config writes,",
             items_sent, results_checked, cfg_writes);
    $display("including unmapped registers, a disabled device, base extremes and a long stall.");
    if (errors == 0) begin
      $display("vectored_interrupt_controller: match");
    end else begin
      $display("%0d result errors", errors);
      $display("vectored_interrupt_controller: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/vic_pkg.sv
sv/vic_ctrl.sv
sv/vic_dp.sv
sv/vectored_interrupt_controller.sv
dv/vectored_interrupt_controller_test.sv
